/* rtl/sqp_pkg.sv */
package sqp_pkg;

   localparam int MemWordsDefault = 256;

   localparam int DataW   = 32;
   localparam int PcW     = 10;
   localparam int LenW    = 9;
   localparam int LdAddrW = 8;
   localparam int StatusW = 3;

   localparam int ReqDataW = 40;
   localparam int RspDataW = 48;
   localparam int CsrAddrW = 3;

   localparam logic [PcW-1:0] PcHalt = '1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EXEC = 1'b1;

   localparam logic CSR_PROGRAM_LENGTH = 1'b0;

   typedef enum logic [StatusW-1:0] {
      ST_STEPPED     = 3'd0,
      ST_HALTED      = 3'd1,
      ST_BAD_LENGTH  = 3'd2,
      ST_OPERAND_OOB = 3'd3,
      ST_PC_OOB      = 3'd4,
      ST_LOADED      = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_FETCH_B,
      S_FETCH_C,
      S_OPERANDS,
      S_READ_VB,
      S_EXECUTE,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      RD_PC,
      RD_PC1,
      RD_PC2,
      RD_A,
      RD_B
   } rd_sel_type;

   typedef struct packed {
      logic       take;
      rd_sel_type rd_sel;
      logic       load;
      logic       check;
      logic       cap_a;
      logic       cap_b;
      logic       operands;
      logic       cap_va;
      logic       exec;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic pre_fail;
      logic operand_fail;
      logic out_free;
   } sts_type;

   // value mod 3 via base-4 digit sums (4 == 1 mod 3)
   function automatic logic len_mult3(input logic [LenW-1:0] v);
      logic [3:0] s;
      logic [2:0] t;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[8]);
      t = 3'(s[1:0]) + 3'(s[3:2]);
      return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
   endfunction

endpackage

/* rtl/subleq_processor_core.sv */
// Load beat: written in S_LOAD, then pushed to the output register from S_DONE.
// Execute beat: S_CHECK, S_FETCH_B, S_FETCH_C, S_OPERANDS, S_READ_VB, S_EXECUTE, S_DONE;
//   early rejects (length, pc, halted, stopped) leave S_CHECK, operand rejects leave S_OPERANDS.
// The word memory has one read port and one write port: three fetches, two operand reads, one write-back.
// Reset (synchronous, active high) clears pc, stop flag, program_length and the output
//   valid flag; memory words stay undefined until loaded.
module subleq_processor_core #(
   parameter int MEM_WORDS = sqp_pkg::MemWordsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sqp_pkg::ReqDataW-1:0]  req_tdata,  // [7:0] address, [39:8] data_word
   input  logic                          req_tuser,  // [0] mode (0 load, 1 execute)
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sqp_pkg::RspDataW-1:0]  rsp_tdata,  // [31:0] written_value, [41:32] next_pc
   output logic [sqp_pkg::StatusW-1:0]   rsp_tuser,  // [2:0] status
   // register port, program_length at byte address 0
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sqp_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   sqp_pkg::cmd_type cmd;
   sqp_pkg::sts_type sts;

   // Sequencer: one beat in flight; a finished result waits in the output
   // register while the next beat is taken.
   sqp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Word memory, pc, stop flag, bounds checks, subtractor and result register.
   sqp_datapath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

   // take a beat only while the sequencer idles
   assign req_tready = cmd.take;
   // register writes and reads complete in the access cycle
   assign csr_pready = 1'b1;

endmodule

/* rtl/sqp_ctrl.sv */
module sqp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tuser,
   input  sqp_pkg::sts_type sts,
   output sqp_pkg::cmd_type cmd
);

   sqp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = sqp_pkg::RD_PC;
      unique case (state_ff)
         sqp_pkg::S_IDLE: begin
            cmd.take = 1'b1;
            if (req_tvalid) begin
               state_in = (req_tuser == sqp_pkg::MODE_LOAD) ? sqp_pkg::S_LOAD
                                                            : sqp_pkg::S_CHECK;
            end
         end
         sqp_pkg::S_LOAD: begin
            cmd.load = 1'b1;
            state_in = sqp_pkg::S_DONE;
         end
         sqp_pkg::S_CHECK: begin
            cmd.check  = 1'b1;
            cmd.rd_sel = sqp_pkg::RD_PC;
            state_in   = sts.pre_fail ? sqp_pkg::S_DONE : sqp_pkg::S_FETCH_B;
         end
         sqp_pkg::S_FETCH_B: begin
            cmd.cap_a  = 1'b1;
            cmd.rd_sel = sqp_pkg::RD_PC1;
            state_in   = sqp_pkg::S_FETCH_C;
         end
         sqp_pkg::S_FETCH_C: begin
            cmd.cap_b  = 1'b1;
            cmd.rd_sel = sqp_pkg::RD_PC2;
            state_in   = sqp_pkg::S_OPERANDS;
         end
         sqp_pkg::S_OPERANDS: begin
            cmd.operands = 1'b1;
            cmd.rd_sel   = sqp_pkg::RD_A;
            state_in     = sts.operand_fail ? sqp_pkg::S_DONE : sqp_pkg::S_READ_VB;
         end
         sqp_pkg::S_READ_VB: begin
            cmd.cap_va = 1'b1;
            cmd.rd_sel = sqp_pkg::RD_B;
            state_in   = sqp_pkg::S_EXECUTE;
         end
         sqp_pkg::S_EXECUTE: begin
            cmd.exec = 1'b1;
            state_in = sqp_pkg::S_DONE;
         end
         sqp_pkg::S_DONE: begin
            // hold until the output register can take the beat
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = sqp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sqp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/sqp_datapath.sv */
module sqp_datapath #(
   parameter int MEM_WORDS = sqp_pkg::MemWordsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sqp_pkg::cmd_type                   cmd,
   output sqp_pkg::sts_type                   sts,
   input  logic                               req_tvalid,
   input  logic [sqp_pkg::ReqDataW-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sqp_pkg::StatusW-1:0]        rsp_tuser,
   output logic [sqp_pkg::RspDataW-1:0]       rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sqp_pkg::CsrAddrW-1:0]       csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata
);

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [31:0] MemWords32 = 32'(MEM_WORDS);

   localparam int DW = sqp_pkg::DataW;
   localparam int PW = sqp_pkg::PcW;
   localparam int LW = sqp_pkg::LenW;

   logic [DW-1:0] mem [MEM_WORDS];
   logic [DW-1:0] rdata_ff;

   logic [sqp_pkg::LdAddrW-1:0] addr_ff, addr_in;
   logic [DW-1:0]               data_ff, data_in;
   logic [PW-1:0]               pc_ff, pc_in;
   logic                        stopped_ff, stopped_in;
   logic [LW-1:0]               len_ff, len_in;
   logic [DW-1:0]               a_ff, a_in, b_ff, b_in, va_ff, va_in;
   logic [PW-1:0]               c_ff, c_in;
   sqp_pkg::status_type         res_status_ff, res_status_in;
   logic [DW-1:0]               res_value_ff, res_value_in;
   logic [PW-1:0]               res_pc_ff, res_pc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sqp_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [DW-1:0]               rsp_value_ff, rsp_value_in;
   logic [PW-1:0]               rsp_pc_ff, rsp_pc_in;

   logic [31:0]         len32;
   logic                len_bad, pc_halt, pc_oob;
   logic [PW:0]         pc_end;
   sqp_pkg::status_type pre_status;
   logic                a_ok, b_ok, c_ok;
   logic [DW-1:0]       diff;
   logic                diff_le0;
   logic [PW-1:0]       pc_step;
   logic [AW-1:0]       pc_idx, rd_addr, wr_addr;
   logic [DW-1:0]       wr_data;
   logic                mem_we, load_hit, csr_wr;

   // checks
   always_comb begin
      len32   = 32'(len_ff);
      len_bad = !sqp_pkg::len_mult3(len_ff) || (len32 > MemWords32);
      pc_halt = (pc_ff == sqp_pkg::PcHalt);
      pc_end  = {1'b0, pc_ff} + (PW+1)'(3);
      pc_oob  = pc_ff[PW-1] || (pc_end > (PW+1)'(len_ff));
      if (len_bad) begin
         pre_status = sqp_pkg::ST_BAD_LENGTH;
      end else if (pc_halt) begin
         pre_status = sqp_pkg::ST_HALTED;
      end else if (pc_oob) begin
         pre_status = sqp_pkg::ST_PC_OOB;
      end else begin
         pre_status = sqp_pkg::ST_HALTED;
      end

      a_ok = !a_ff[DW-1] && (a_ff < len32);
      b_ok = !b_ff[DW-1] && (b_ff < len32);
      c_ok = (rdata_ff == '1) || (!rdata_ff[DW-1] && (rdata_ff < len32));

      diff     = rdata_ff - va_ff;
      diff_le0 = diff[DW-1] || (diff == '0);
      pc_step  = pc_ff + PW'(3);

      sts.pre_fail     = len_bad || pc_halt || pc_oob || stopped_ff;
      sts.operand_fail = !(a_ok && b_ok && c_ok);
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // memory port addressing
   always_comb begin
      pc_idx = AW'(pc_ff);
      unique case (cmd.rd_sel)
         sqp_pkg::RD_PC:  rd_addr = pc_idx;
         sqp_pkg::RD_PC1: rd_addr = pc_idx + AW'(1);
         sqp_pkg::RD_PC2: rd_addr = pc_idx + AW'(2);
         sqp_pkg::RD_A:   rd_addr = AW'(a_ff);
         sqp_pkg::RD_B:   rd_addr = AW'(b_ff);
         default:         rd_addr = pc_idx;
      endcase
      load_hit = 32'(addr_ff) < MemWords32;
      mem_we   = (cmd.load && load_hit) || cmd.exec;
      wr_addr  = cmd.exec ? AW'(b_ff) : AW'(addr_ff);
      wr_data  = cmd.exec ? diff : data_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      addr_in       = addr_ff;
      data_in       = data_ff;
      pc_in         = pc_ff;
      stopped_in    = stopped_ff;
      len_in        = len_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      va_in         = va_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_pc_in     = res_pc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pc_in     = rsp_pc_ff;

      if (cmd.take && req_tvalid) begin
         addr_in = req_tdata[7:0];
         data_in = req_tdata[39:8];
      end
      if (cmd.load) begin
         pc_in         = '0;
         stopped_in    = 1'b0;
         res_status_in = sqp_pkg::ST_LOADED;
         res_value_in  = '0;
         res_pc_in     = '0;
      end
      if (cmd.check && sts.pre_fail) begin
         stopped_in    = 1'b1;
         res_status_in = pre_status;
         res_value_in  = '0;
         res_pc_in     = pc_ff;
      end
      if (cmd.cap_a) begin
         a_in = rdata_ff;
      end
      if (cmd.cap_b) begin
         b_in = rdata_ff;
      end
      if (cmd.operands) begin
         c_in = rdata_ff[PW-1:0];
         if (sts.operand_fail) begin
            stopped_in    = 1'b1;
            res_status_in = sqp_pkg::ST_OPERAND_OOB;
            res_value_in  = '0;
            res_pc_in     = pc_ff;
         end
      end
      if (cmd.cap_va) begin
         va_in = rdata_ff;
      end
      if (cmd.exec) begin
         pc_in         = diff_le0 ? c_ff : pc_step;
         res_status_in = sqp_pkg::ST_STEPPED;
         res_value_in  = diff;
         res_pc_in     = diff_le0 ? c_ff : pc_step;
      end
      if (cmd.push) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
         rsp_pc_in     = res_pc_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr && (csr_paddr[2] == sqp_pkg::CSR_PROGRAM_LENGTH)) begin
         len_in = csr_pwdata[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         stopped_ff   <= stopped_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      data_ff       <= data_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      va_ff         <= va_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_pc_ff     <= res_pc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pc_ff     <= rsp_pc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_pc_ff, rsp_value_ff};
   assign csr_prdata = (csr_paddr[2] == sqp_pkg::CSR_PROGRAM_LENGTH) ? 32'(len_ff) : 32'd0;

endmodule
